>>> sv/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDTQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SDTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/sdtq_pkg.sv
// shared widths, codes and types of the sorted deadline timer queue
package sdtq_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int RESULT_CAP = 16;
   localparam int CNT_W      = $clog2(RESULT_CAP);
   localparam int ID_W       = 10;
   localparam int DL_W       = 32;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ADJUST = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] dl;
   } cell_data_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [ID_W-1:0] key_id;
      logic [DL_W-1:0] key_dl;
   } cell_cmd_type;

endpackage

>>> sv/sorted_deadline_timer_queue_unit.sv
// sorted deadline timer queue: top level with control sequencer and cell chain
// add, delete and not-found answers are registered from the find state, adjust from the insert state
// tick: results leave the tick state, one expired result per cycle while the output register is free
// an item passes idle, find and, for adjust, insert; a tick stays in the tick state until its last result
// output register lets the next request in while a result waits
// synchronous reset empties every cell and the output register
module sorted_deadline_timer_queue_unit #(
   parameter int MAX_TIMERS = sdtq_pkg::MAX_TIMERS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sdtq_pkg::REQ_DATA_W-1:0] req_tdata,  // timer_id, deadline, now, zero pad
   input  logic [sdtq_pkg::REQ_W-1:0]      req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdtq_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_id, zero pad
   output logic [sdtq_pkg::STATUS_W-1:0]   rsp_tuser,  // status
   output logic                            rsp_tlast
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_FIND   = 2'd1;
   localparam logic [1:0] S_INSERT = 2'd2;
   localparam logic [1:0] S_TICK   = 2'd3;

   localparam int ID_W  = sdtq_pkg::ID_W;
   localparam int DL_W  = sdtq_pkg::DL_W;
   localparam int CNT_W = sdtq_pkg::CNT_W;

   logic [1:0]                    state_ff, state_in;
   logic [sdtq_pkg::REQ_W-1:0]    op_ff, op_in;
   logic [ID_W-1:0]               id_ff, id_in;
   logic [DL_W-1:0]               dl_ff, dl_in;
   logic [DL_W-1:0]               now_ff, now_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]               rsp_id_ff, rsp_id_in;
   logic [sdtq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          emit;
   logic [1:0]                    cell_op;
   logic                          pop;
   logic                          any_match;
   logic                          full;
   logic                          head_last;

   sdtq_pkg::cell_cmd_type        cmd;
   sdtq_pkg::cell_data_type       cell_data [MAX_TIMERS];
   logic [MAX_TIMERS-1:0]         cell_le;
   logic [MAX_TIMERS-1:0]         cell_match;
   logic [MAX_TIMERS:0]           hit_chain;

   assign cmd.op     = cell_op;
   assign cmd.key_id = id_ff;
   assign cmd.key_dl = (state_ff == S_TICK) ? now_ff : dl_ff;
   assign hit_chain[0] = pop;

   for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
      sdtq_pkg::cell_data_type left_d, right_d;
      logic                    left_le_w;
      if (g == 0) begin : g_head
         assign left_d    = '0;
         assign left_le_w = 1'b1;
      end else begin : g_body
         assign left_d    = cell_data[g-1];
         assign left_le_w = cell_le[g-1];
      end
      if (g == MAX_TIMERS - 1) begin : g_tail
         assign right_d = '0;
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      sdtq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_data  (left_d),
         .left_le    (left_le_w),
         .right_data (right_d),
         .hit_in     (hit_chain[g]),
         .data       (cell_data[g]),
         .le         (cell_le[g]),
         .hit_out    (hit_chain[g+1]),
         .match      (cell_match[g])
      );
   end

   assign any_match = |cell_match;
   assign full      = cell_data[MAX_TIMERS-1].valid;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign head_last = (cnt_ff == CNT_W'(sdtq_pkg::RESULT_CAP - 1)) || !cell_le[1];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      dl_in         = dl_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      req_tready    = 1'b0;
      emit          = 1'b0;
      cell_op       = sdtq_pkg::CELL_HOLD;
      pop           = 1'b0;
      rsp_id_in     = id_ff;
      rsp_status_in = sdtq_pkg::ST_DONE;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               dl_in    = req_tdata[ID_W+DL_W-1:ID_W];
               now_in   = req_tdata[ID_W+2*DL_W-1:ID_W+DL_W];
               cnt_in   = '0;
               state_in = (req_tuser == sdtq_pkg::REQ_TICK) ? S_TICK : S_FIND;
            end
         end
         S_FIND: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  sdtq_pkg::REQ_ADD: begin
                     if (any_match) begin
                        rsp_status_in = sdtq_pkg::ST_DUPLICATE;
                     end else if (full) begin
                        rsp_status_in = sdtq_pkg::ST_FULL;
                     end else begin
                        cell_op = sdtq_pkg::CELL_INSERT;
                     end
                  end
                  sdtq_pkg::REQ_ADJUST: begin
                     if (any_match) begin
                        cell_op  = sdtq_pkg::CELL_SHIFT;
                        emit     = 1'b0;
                        state_in = S_INSERT;
                     end else begin
                        rsp_status_in = sdtq_pkg::ST_NOT_FOUND;
                     end
                  end
                  sdtq_pkg::REQ_DELETE: begin
                     if (any_match) begin
                        cell_op = sdtq_pkg::CELL_SHIFT;
                     end else begin
                        rsp_status_in = sdtq_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         S_INSERT: begin
            if (out_free) begin
               cell_op  = sdtq_pkg::CELL_INSERT;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               emit = 1'b1;
               if (cell_le[0]) begin
                  cell_op       = sdtq_pkg::CELL_SHIFT;
                  pop           = 1'b1;
                  rsp_id_in     = cell_data[0].id;
                  rsp_status_in = sdtq_pkg::ST_EXPIRED;
                  rsp_last_in   = head_last;
                  cnt_in        = cnt_ff + 1'b1;
                  if (head_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_id_in     = '0;
                  rsp_status_in = sdtq_pkg::ST_NONE_DUE;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      id_ff  <= id_in;
      dl_ff  <= dl_in;
      now_ff <= now_in;
      cnt_ff <= cnt_in;
      if (emit) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sdtq_pkg::RSP_DATA_W - ID_W){1'b0}}, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sv/sdtq_cell.sv
// one slot of the sorted timer chain
module sdtq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sdtq_pkg::cell_cmd_type  cmd,
   input  sdtq_pkg::cell_data_type left_data,
   input  logic                  left_le,
   input  sdtq_pkg::cell_data_type right_data,
   input  logic                  hit_in,
   output sdtq_pkg::cell_data_type data,
   output logic                  le,
   output logic                  hit_out,
   output logic                  match
);

   logic                      valid_ff, valid_in;
   logic [sdtq_pkg::ID_W-1:0] id_ff, id_in;
   logic [sdtq_pkg::DL_W-1:0] dl_ff, dl_in;

   assign data    = '{valid: valid_ff, id: id_ff, dl: dl_ff};
   assign le      = valid_ff && (dl_ff <= cmd.key_dl);
   assign match   = valid_ff && (id_ff == cmd.key_id);
   assign hit_out = hit_in | match;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      dl_in    = dl_ff;
      case (cmd.op)
         sdtq_pkg::CELL_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  id_in    = cmd.key_id;
                  dl_in    = cmd.key_dl;
               end else begin
                  valid_in = left_data.valid;
                  id_in    = left_data.id;
                  dl_in    = left_data.dl;
               end
            end
         end
         sdtq_pkg::CELL_SHIFT: begin
            if (hit_out) begin
               valid_in = right_data.valid;
               id_in    = right_data.id;
               dl_in    = right_data.dl;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
      dl_ff <= dl_in;
   end

endmodule

>>> sv/sdtq_checker.sv
// port-level checks of the timer queue, bound to the top level
`include "assert_macros.svh"

module sdtq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sdtq_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [sdtq_pkg::REQ_W-1:0]      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sdtq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sdtq_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                            rsp_tlast
);

   logic                                              single_status;
   logic                                              none_due;
   logic                                              none_due_form;
   logic                                              rsp_wait;
   logic [sdtq_pkg::RSP_DATA_W+sdtq_pkg::STATUS_W:0] rsp_bundle;

   assign single_status = rsp_tuser inside {sdtq_pkg::ST_DONE, sdtq_pkg::ST_FULL,
                                            sdtq_pkg::ST_NOT_FOUND, sdtq_pkg::ST_DUPLICATE};
   assign none_due      = (rsp_tuser == sdtq_pkg::ST_NONE_DUE);
   assign none_due_form = rsp_tlast && (rsp_tdata == '0);
   assign rsp_wait      = rsp_tvalid && !rsp_tready;
   assign rsp_bundle    = {rsp_tdata, rsp_tuser, rsp_tlast};

   `SDTQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SDTQ_ASSERT_NOW(a_single_is_last, clock, reset, rsp_tvalid && single_status, rsp_tlast)
   `SDTQ_ASSERT_NOW(a_none_due_form, clock, reset, rsp_tvalid && none_due, none_due_form)
   `SDTQ_ASSERT_NOW(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= sdtq_pkg::ST_DUPLICATE)
   `SDTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_bundle))

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (.*);

>>> tb/sv/sorted_deadline_timer_queue_unit_tb.sv
// self-checking testbench of the sorted deadline timer queue: directed, random and backpressure
module sorted_deadline_timer_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HANDLE_POOL = 24;

   localparam int ID_W       = sdtq_pkg::ID_W;
   localparam int DL_W       = sdtq_pkg::DL_W;
   localparam int REQ_W      = sdtq_pkg::REQ_W;
   localparam int STATUS_W   = sdtq_pkg::STATUS_W;
   localparam int REQ_DATA_W = sdtq_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = sdtq_pkg::RSP_DATA_W;
   localparam int MAX_TIMERS = sdtq_pkg::MAX_TIMERS;
   localparam int RESULT_CAP = sdtq_pkg::RESULT_CAP;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [STATUS_W-1:0] status;
      logic                last;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   // predicted timer list, ascending deadline order
   logic [DL_W-1:0] sched_dl [MAX_TIMERS];
   logic [ID_W-1:0] sched_id [MAX_TIMERS];
   int              sched_len = 0;
   answer_type      pending_answers[$];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          tx_idle_pct = 36;
   int          rx_idle_pct = 36;
   int          hold_request = 0;
   int          hold_left = 0;
   logic [DL_W-1:0] cur_time = '0;

   sorted_deadline_timer_queue_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < sched_len; i++) begin
         if (sched_id[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < sched_len; i++) begin
         sched_dl[i] = sched_dl[i+1];
         sched_id[i] = sched_id[i+1];
      end
      sched_len--;
   endfunction

   function automatic void place_timer(logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
      int pos;
      pos = 0;
      while (pos < sched_len && sched_dl[pos] <= dl) pos++;
      for (int i = sched_len; i > pos; i--) begin
         sched_dl[i] = sched_dl[i-1];
         sched_id[i] = sched_id[i-1];
      end
      sched_dl[pos] = dl;
      sched_id[pos] = id;
      sched_len++;
   endfunction

   function automatic void push_answer(logic [ID_W-1:0] id, logic [STATUS_W-1:0] st,
                                       logic last);
      answer_type a;
      a.id = id;
      a.status = st;
      a.last = last;
      pending_answers.push_back(a);
   endfunction

   function automatic void predict_answers(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                           logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
      int pos;
      int n;
      bit more;
      logic [ID_W-1:0] due_id;
      case (req)
         sdtq_pkg::REQ_ADD: begin
            if (find_slot(id) >= 0) begin
               push_answer(id, sdtq_pkg::ST_DUPLICATE, 1'b1);
            end else if (sched_len >= MAX_TIMERS) begin
               push_answer(id, sdtq_pkg::ST_FULL, 1'b1);
            end else begin
               place_timer(id, dl);
               push_answer(id, sdtq_pkg::ST_DONE, 1'b1);
            end
         end
         sdtq_pkg::REQ_ADJUST, sdtq_pkg::REQ_DELETE: begin
            pos = find_slot(id);
            if (pos < 0) begin
               push_answer(id, sdtq_pkg::ST_NOT_FOUND, 1'b1);
            end else begin
               drop_slot(pos);
               if (req == sdtq_pkg::REQ_ADJUST) place_timer(id, dl);
               push_answer(id, sdtq_pkg::ST_DONE, 1'b1);
            end
         end
         default: begin
            n = 0;
            while (n < RESULT_CAP && sched_len > 0 && sched_dl[0] <= now) begin
               due_id = sched_id[0];
               drop_slot(0);
               n++;
               more = (n < RESULT_CAP && sched_len > 0 && sched_dl[0] <= now);
               push_answer(due_id, sdtq_pkg::ST_EXPIRED, !more);
            end
            if (n == 0) push_answer('0, sdtq_pkg::ST_NONE_DUE, 1'b1);
         end
      endcase
   endfunction

   task automatic send_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                           logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req;
      req_tdata  <= {6'b0, now, dl, id};
      do @(posedge clock); while (!req_tready);
      predict_answers(req, id, dl, now);
   endtask

   task automatic send_random_item();
      logic [REQ_W-1:0] req;
      logic [ID_W-1:0]  id;
      logic [DL_W-1:0]  dl;
      logic [DL_W-1:0]  now;
      int r;
      r = $urandom_range(99);
      if (r < 40) req = sdtq_pkg::REQ_ADD;
      else if (r < 60) req = sdtq_pkg::REQ_ADJUST;
      else if (r < 75) req = sdtq_pkg::REQ_DELETE;
      else req = sdtq_pkg::REQ_TICK;
      r = $urandom_range(99);
      if (r < 10 && sched_len > 0) id = sched_id[$urandom_range(sched_len - 1)];
      else if (r < 85) id = ID_W'($urandom_range(HANDLE_POOL - 1));
      else id = ID_W'($urandom_range(1023));
      r = $urandom_range(99);
      if (r < 10 && sched_len > 0) dl = sched_dl[$urandom_range(sched_len - 1)];
      else if (r < 80) dl = cur_time + DL_W'($urandom_range(300));
      else dl = $urandom;
      if ($urandom_range(99) < 85) begin
         cur_time = cur_time + DL_W'($urandom_range(80));
         now = cur_time;
      end else begin
         now = $urandom;
      end
      send_req(req, id, dl, now);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_tick();
      send_req(sdtq_pkg::REQ_TICK, '0, '0, '0);
      drain();
   endtask

   task automatic test_basic_ops();
      send_req(sdtq_pkg::REQ_ADD, '0, '0, '0);
      send_req(sdtq_pkg::REQ_ADD, '1, '1, '0);
      send_req(sdtq_pkg::REQ_ADD, 10'd5, 32'd100, '0);
      send_req(sdtq_pkg::REQ_ADD, 10'd5, 32'd7, '0);
      send_req(sdtq_pkg::REQ_ADJUST, 10'd7, 32'd1, '0);
      send_req(sdtq_pkg::REQ_DELETE, 10'd9, '0, '1);
      // equal deadline after adjust lands behind the older entry
      send_req(sdtq_pkg::REQ_ADJUST, '1, 32'd100, '0);
      send_req(sdtq_pkg::REQ_TICK, '0, '0, 32'd99);
      send_req(sdtq_pkg::REQ_DELETE, 10'd5, '0, '0);
      send_req(sdtq_pkg::REQ_TICK, '0, '1, '1);
      drain();
   endtask

   task automatic test_full_queue();
      for (int i = 0; i < MAX_TIMERS; i++) begin
         send_req(sdtq_pkg::REQ_ADD, ID_W'(i * 64 + 3), $urandom, '0);
      end
      send_req(sdtq_pkg::REQ_ADD, 10'd1000, 32'd5, '0);
      send_req(sdtq_pkg::REQ_ADD, ID_W'(3), 32'd5, '0);
      send_req(sdtq_pkg::REQ_TICK, '0, '0, '1);
      drain();
   endtask

   task automatic test_random_mix();
      tx_idle_pct = 36;
      rx_idle_pct = 36;
      repeat (85) send_random_item();
      drain();
   endtask

   task automatic test_back_to_back();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (40) send_random_item();
      drain();
      tx_idle_pct = 36;
      rx_idle_pct = 36;
   endtask

   task automatic test_output_backpressure();
      hold_request = 300;
      tx_idle_pct = 0;
      repeat (6) send_req(sdtq_pkg::REQ_ADD, ID_W'($urandom_range(HANDLE_POOL - 1)),
                          cur_time + DL_W'($urandom_range(20)), '0);
      cur_time = cur_time + 32'd40;
      send_req(sdtq_pkg::REQ_TICK, '0, '0, cur_time);
      repeat (20) send_random_item();
      drain();
      tx_idle_pct = 36;
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: id=%0d status=%0d last=%0b",
                        rsp_tdata[ID_W-1:0], rsp_tuser, rsp_tlast);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[ID_W-1:0] !== want.id || rsp_tuser !== want.status
                || rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want id=%0d st=%0d last=%0b, got id=%0d st=%0d last=%0b",
                           want.id, want.status, want.last,
                           rsp_tdata[ID_W-1:0], rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL sorted_deadline_timer_queue_unit");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tick();
      test_basic_ops();
      test_full_queue();
      test_random_mix();
      test_back_to_back();
      test_output_backpressure();
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("PASS sorted_deadline_timer_queue_unit");
      end else begin
         $display("FAIL sorted_deadline_timer_queue_unit");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue_unit.sv
sv/sdtq_checker.sv
tb/sv/sorted_deadline_timer_queue_unit_tb.sv
